FILE: src/ttpp_pkg.sv
// Shared types, constants and tables for the target to pan/tilt pulse unit.
package ttpp_pkg;

  // Input and result words
  typedef struct packed {
    logic signed [11:0] target_x;
    logic        [11:0] target_y;
  } in_word_t;

  typedef struct packed {
    logic [11:0] tilt_pulse;
    logic [11:0] pan_pulse;
  } out_word_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_Y_GAIN          = 3'd0,
    REG_Y_OFFSET        = 3'd1,
    REG_PAN_DISTANCE    = 3'd2,
    REG_TILT_DISTANCE   = 3'd3,
    REG_SKEW_GAIN       = 3'd4,
    REG_PULSE_BASE      = 3'd5,
    REG_PULSE_HALF_SPAN = 3'd6,
    REG_PULSE_PER_RAD   = 3'd7
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [10:0] Y_GAIN_RST          = 11'd829;
  localparam logic [9:0]  Y_OFFSET_RST        = 10'd141;
  localparam logic [12:0] PAN_DISTANCE_RST    = 13'd3203;
  localparam logic [12:0] TILT_DISTANCE_RST   = 13'd3200;
  localparam logic [11:0] SKEW_GAIN_RST       = 12'd1049;
  localparam logic [11:0] PULSE_BASE_RST      = 12'd500;
  localparam logic [11:0] PULSE_HALF_SPAN_RST = 12'd1000;
  localparam logic [15:0] PULSE_PER_RAD_RST   = 16'd10191;

  // Arithmetic
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX_STEPS = 24;
  localparam int COORD_FRAC_BITS  = 6;
  localparam int GUARD_BITS       = 24;
  localparam int CW               = 52;  // CORDIC x/y datapath, signed
  localparam int ZW               = 19;  // accumulated angle, Q16, signed
  localparam int RW               = ZW + 1;  // angle after skew, signed
  localparam int SKEW_PROD_W      = 24;
  localparam int SKEW_SHIFT       = COORD_FRAC_BITS + 4;
  localparam int SKW              = SKEW_PROD_W - SKEW_SHIFT;
  localparam int PPR_SHIFT        = 20;
  localparam int CNTW             = RW + 16 - PPR_SHIFT;
  localparam int SUMW             = 19;
  localparam logic [11:0] PULSE_MAX = 12'd4095;

  // atan(2^-i) in Q16, rounded to nearest
  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] a;
    case (idx)
      5'd0:    a = 17'd51472;
      5'd1:    a = 17'd30386;
      5'd2:    a = 17'd16055;
      5'd3:    a = 17'd8150;
      5'd4:    a = 17'd4091;
      5'd5:    a = 17'd2047;
      5'd6:    a = 17'd1024;
      5'd7:    a = 17'd512;
      5'd8:    a = 17'd256;
      5'd9:    a = 17'd128;
      5'd10:   a = 17'd64;
      5'd11:   a = 17'd32;
      5'd12:   a = 17'd16;
      5'd13:   a = 17'd8;
      5'd14:   a = 17'd4;
      5'd15:   a = 17'd2;
      5'd16:   a = 17'd1;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

  // Clamp a signed sum to the pulse range
  function automatic logic [11:0] sat_pulse(input logic signed [SUMW-1:0] v);
    logic [11:0] r;
    if (v[SUMW-1]) begin
      r = 12'd0;
    end else if (v > $signed(SUMW'(PULSE_MAX))) begin
      r = PULSE_MAX;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

FILE: src/target_to_pan_tilt_pulse_unit.sv
// Target point to pan/tilt servo pulse widths: prep, unrolled CORDIC, scaling, output.
// Pipeline: CORDIC_STEPS + 4 register stages; out_valid rises when a word reaches the output
// register; the word is taken at an edge with out_stall low. Throughput: one word per cycle
// unless out_stall holds it; one CORDIC iteration per stage, pan and tilt side by side.
// A stalled output register holds the whole pipeline, so in_stall follows out_stall then.
// Reset (rst_n low, synchronous): valid bits cleared, config registers to defaults.
// Datapath registers carry no reset.
module target_to_pan_tilt_pulse_unit #(
  parameter int CORDIC_STEPS = ttpp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ttpp_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ttpp_pkg::out_word_t              out_word,
  input  logic                             cfg_wr_en,
  input  ttpp_pkg::cfg_idx_t               cfg_index,
  input  logic [ttpp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int N  = CORDIC_STEPS;
  localparam int NS = N + 4;
  localparam int CW = ttpp_pkg::CW;
  localparam int ZW = ttpp_pkg::ZW;
  localparam int RW = ttpp_pkg::RW;
  localparam int SKW = ttpp_pkg::SKW;
  localparam int CNTW = ttpp_pkg::CNTW;
  localparam int SUMW = ttpp_pkg::SUMW;
  localparam int GB = ttpp_pkg::GUARD_BITS;

  // ---------------- configuration ----------------
  logic [10:0] y_gain_r;
  logic [9:0]  y_offset_r;
  logic [12:0] pan_distance_r;
  logic [12:0] tilt_distance_r;
  logic [11:0] skew_gain_r;
  logic [11:0] pulse_base_r;
  logic [11:0] pulse_half_span_r;
  logic [15:0] pulse_per_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_gain_r          <= ttpp_pkg::Y_GAIN_RST;
      y_offset_r        <= ttpp_pkg::Y_OFFSET_RST;
      pan_distance_r    <= ttpp_pkg::PAN_DISTANCE_RST;
      tilt_distance_r   <= ttpp_pkg::TILT_DISTANCE_RST;
      skew_gain_r       <= ttpp_pkg::SKEW_GAIN_RST;
      pulse_base_r      <= ttpp_pkg::PULSE_BASE_RST;
      pulse_half_span_r <= ttpp_pkg::PULSE_HALF_SPAN_RST;
      pulse_per_rad_r   <= ttpp_pkg::PULSE_PER_RAD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ttpp_pkg::REG_Y_GAIN:          y_gain_r          <= cfg_wdata[10:0];
        ttpp_pkg::REG_Y_OFFSET:        y_offset_r        <= cfg_wdata[9:0];
        ttpp_pkg::REG_PAN_DISTANCE:    pan_distance_r    <= cfg_wdata[12:0];
        ttpp_pkg::REG_TILT_DISTANCE:   tilt_distance_r   <= cfg_wdata[12:0];
        ttpp_pkg::REG_SKEW_GAIN:       skew_gain_r       <= cfg_wdata[11:0];
        ttpp_pkg::REG_PULSE_BASE:      pulse_base_r      <= cfg_wdata[11:0];
        ttpp_pkg::REG_PULSE_HALF_SPAN: pulse_half_span_r <= cfg_wdata[11:0];
        ttpp_pkg::REG_PULSE_PER_RAD:   pulse_per_rad_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [NS-1:0] v_r;
  logic          adv;

  assign adv       = !v_r[NS-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  // ---------------- stage 0: prep ----------------
  logic signed [CW-1:0]  pcx_r [0:N];
  logic signed [CW-1:0]  pcy_r [0:N];
  logic signed [ZW-1:0]  pz_r  [0:N];
  logic signed [CW-1:0]  tcx_r [0:N];
  logic signed [CW-1:0]  tcy_r [0:N];
  logic signed [ZW-1:0]  tz_r  [0:N];
  logic                  nn_r  [0:N];
  logic [SKW-1:0]        skew_r [0:N];

  logic                           nn_nxt;
  logic [12:0]                    xneg;
  logic [11:0]                    ax;
  logic [12:0]                    pd;
  logic [12:0]                    td;
  logic [23:0]                    y2;
  logic [ttpp_pkg::SKEW_PROD_W-1:0] skew_prod;
  logic [SKW-1:0]                 skew_nxt;

  always_comb begin
    nn_nxt    = !in_word.target_x[11];
    xneg      = -{in_word.target_x[11], in_word.target_x};
    ax        = nn_nxt ? 12'(in_word.target_x) : xneg[11:0];
    // zero distance acts as one
    pd        = (pan_distance_r == '0) ? 13'd1 : pan_distance_r;
    td        = (tilt_distance_r == '0) ? 13'd1 : tilt_distance_r;
    y2        = 24'(in_word.target_y) * 24'(y_gain_r) + 24'({y_offset_r, 10'b0});
    skew_prod = 24'(ax) * 24'(skew_gain_r);
    skew_nxt  = skew_prod[ttpp_pkg::SKEW_PROD_W-1:ttpp_pkg::SKEW_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pcx_r[0]  <= CW'({pd, {GB{1'b0}}});
      pcy_r[0]  <= CW'({ax, {GB{1'b0}}});
      pz_r[0]   <= '0;
      tcx_r[0]  <= CW'({td, 10'b0, {GB{1'b0}}});
      tcy_r[0]  <= CW'({y2, {GB{1'b0}}});
      tz_r[0]   <= '0;
      nn_r[0]   <= nn_nxt;
      skew_r[0] <= skew_nxt;
    end
  end

  // ---------------- CORDIC stages, vectoring mode ----------------
  for (genvar k = 0; k < N; k++) begin : g_cordic
    localparam logic signed [ZW-1:0] ANG = ZW'(ttpp_pkg::atan_q16(5'(k)));

    logic signed [CW-1:0] pcx_nxt, pcy_nxt, tcx_nxt, tcy_nxt;
    logic signed [ZW-1:0] pz_nxt, tz_nxt;
    logic signed [CW-1:0] pdx, pdy, tdx, tdy;

    always_comb begin
      pdx = pcy_r[k] >>> k;
      pdy = pcx_r[k] >>> k;
      tdx = tcy_r[k] >>> k;
      tdy = tcx_r[k] >>> k;
      pcx_nxt = pcx_r[k];
      pcy_nxt = pcy_r[k];
      pz_nxt  = pz_r[k];
      tcx_nxt = tcx_r[k];
      tcy_nxt = tcy_r[k];
      tz_nxt  = tz_r[k];
      // a residual of exactly zero leaves the step alone
      if (pcy_r[k][CW-1]) begin
        pcx_nxt = pcx_r[k] - pdx;
        pcy_nxt = pcy_r[k] + pdy;
        pz_nxt  = pz_r[k] - ANG;
      end else if (pcy_r[k] != '0) begin
        pcx_nxt = pcx_r[k] + pdx;
        pcy_nxt = pcy_r[k] - pdy;
        pz_nxt  = pz_r[k] + ANG;
      end
      if (tcy_r[k][CW-1]) begin
        tcx_nxt = tcx_r[k] - tdx;
        tcy_nxt = tcy_r[k] + tdy;
        tz_nxt  = tz_r[k] - ANG;
      end else if (tcy_r[k] != '0) begin
        tcx_nxt = tcx_r[k] + tdx;
        tcy_nxt = tcy_r[k] - tdy;
        tz_nxt  = tz_r[k] + ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pcx_r[k+1]  <= pcx_nxt;
        pcy_r[k+1]  <= pcy_nxt;
        pz_r[k+1]   <= pz_nxt;
        tcx_r[k+1]  <= tcx_nxt;
        tcy_r[k+1]  <= tcy_nxt;
        tz_r[k+1]   <= tz_nxt;
        nn_r[k+1]   <= nn_r[k];
        skew_r[k+1] <= skew_r[k];
      end
    end
  end

  // ---------------- M1: skew correction, sign/magnitude ----------------
  logic signed [RW-1:0] pan_rad, tilt_rad;
  logic [RW-1:0]        pan_mag_nxt, tilt_mag_nxt;
  logic [RW-1:0]        pan_mag_r, tilt_mag_r;
  logic                 pan_neg_r, tilt_neg_r, nn1_r;

  always_comb begin
    pan_rad  = RW'(pz_r[N]);
    tilt_rad = RW'(tz_r[N]) - (nn_r[N] ? $signed(RW'(skew_r[N])) : '0);
    pan_mag_nxt  = pan_rad[RW-1]  ? RW'(-pan_rad)  : RW'(pan_rad);
    tilt_mag_nxt = tilt_rad[RW-1] ? RW'(-tilt_rad) : RW'(tilt_rad);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pan_mag_r  <= pan_mag_nxt;
      tilt_mag_r <= tilt_mag_nxt;
      pan_neg_r  <= pan_rad[RW-1];
      tilt_neg_r <= tilt_rad[RW-1];
      nn1_r      <= nn_r[N];
    end
  end

  // ---------------- M2: angle to counts ----------------
  logic [RW+15:0]   pan_prod, tilt_prod;
  logic [CNTW-1:0]  pan_cnt_r, tilt_cnt_r;
  logic             pan_sub_r, tilt_neg2_r;

  always_comb begin
    pan_prod  = (RW+16)'(pan_mag_r) * (RW+16)'(pulse_per_rad_r);
    tilt_prod = (RW+16)'(tilt_mag_r) * (RW+16)'(pulse_per_rad_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pan_cnt_r   <= pan_prod[RW+15:ttpp_pkg::PPR_SHIFT];
      tilt_cnt_r  <= tilt_prod[RW+15:ttpp_pkg::PPR_SHIFT];
      // pan term is subtracted when angle sign and x sign disagree
      pan_sub_r   <= pan_neg_r ^ !nn1_r;
      tilt_neg2_r <= tilt_neg_r;
    end
  end

  // ---------------- M3: offset, saturate, output register ----------------
  logic signed [SUMW-1:0] pan_sum, tilt_sum, pan_term, tilt_term;
  ttpp_pkg::out_word_t    out_nxt;
  ttpp_pkg::out_word_t    out_r;

  always_comb begin
    pan_term  = pan_sub_r   ? -$signed(SUMW'(pan_cnt_r))  : $signed(SUMW'(pan_cnt_r));
    tilt_term = tilt_neg2_r ? -$signed(SUMW'(tilt_cnt_r)) : $signed(SUMW'(tilt_cnt_r));
    pan_sum   = $signed(SUMW'(pulse_base_r)) + $signed(SUMW'(pulse_half_span_r)) + pan_term;
    tilt_sum  = $signed(SUMW'(pulse_base_r)) + tilt_term;
    out_nxt.tilt_pulse = ttpp_pkg::sat_pulse(tilt_sum);
    out_nxt.pan_pulse  = ttpp_pkg::sat_pulse(pan_sum);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_word = out_r;

endmodule

FILE: src/ttpp_checker.sv
// Port-level checks for the pan/tilt pulse unit, bound to the top level.
module ttpp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ttpp_pkg::out_word_t out_word
);

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed or dropped while stalled");

  // input side stalls exactly when a finished word is blocked
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not track blocked output");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("out_valid set right after reset");

  // an offered word is never stalled while the output register is empty
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> !in_stall)
    else $error("stall raised with empty output register");

endmodule

bind target_to_pan_tilt_pulse_unit ttpp_checker u_ttpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
